// File: rtl/dlcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dlcf_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHT_RED   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHT_GREEN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHT_BLUE  = 2'd2;

   // Brightness byte that leaves a channel unchanged
   localparam logic [7:0] BRIGHT_NEUTRAL = 8'h80;

   // Input beat
   typedef struct packed {
      logic [31:0] list_word;
      logic        end_of_list;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [31:0] out_word;
      logic        out_last;
      logic        bad_code;
   } rsp_type;

   // Per-word decision from the position tracker
   typedef struct packed {
      logic fade_en;
      logic bad_code;
   } trk_status_type;

endpackage

`default_nettype wire

// File: rtl/dlcf_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module dlcf_lane (
   input  wire logic [7:0] color_byte,
   input  wire logic [7:0] bright_byte,
   output logic      [7:0] faded_byte
);

   localparam logic [8:0] DIM_BIAS = 9'h07f;
   localparam logic [8:0] SAT_MAX  = 9'h0ff;

   logic [8:0] sum;

   assign sum = {1'b0, color_byte} + {1'b0, bright_byte};

   // Darken below 0x7f, pass at 0x7f and at neutral, brighten above neutral
   always_comb begin
      priority if (bright_byte <= DIM_BIAS[7:0]) begin
         if (sum < DIM_BIAS) begin
            faded_byte = 8'h00;
         end else begin
            faded_byte = 8'(sum - DIM_BIAS);
         end
      end else if (bright_byte == dlcf_pkg::BRIGHT_NEUTRAL) begin
         faded_byte = color_byte;
      end else if (sum > SAT_MAX) begin
         faded_byte = 8'hff;
      end else begin
         faded_byte = sum[7:0];
      end
   end

endmodule

`default_nettype wire

// File: rtl/dlcf_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

module dlcf_tracker (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [7:0]               code_byte,
   input  wire logic                     end_of_list,
   output dlcf_pkg::trk_status_type      status
);

   // Primitive codes after masking
   localparam logic [7:0] CODE_MASK             = 8'hfc;
   localparam logic [7:0] CODE_TRI_PLAIN        = 8'h20;
   localparam logic [7:0] CODE_TRI_FLAT         = 8'h24;
   localparam logic [7:0] CODE_QUAD_PLAIN       = 8'h28;
   localparam logic [7:0] CODE_QUAD_FLAT        = 8'h2c;
   localparam logic [7:0] CODE_TRI_SHADE_PLAIN  = 8'h30;
   localparam logic [7:0] CODE_TRI_GOURAUD      = 8'h34;
   localparam logic [7:0] CODE_QUAD_SHADE_PLAIN = 8'h38;
   localparam logic [7:0] CODE_QUAD_GOURAUD     = 8'h3c;

   // Color kinds
   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_FLAT    = 2'd1;
   localparam logic [1:0] KIND_GOURAUD = 2'd2;

   // Word positions of interest
   localparam logic [3:0] POS_TAG     = 4'd0;
   localparam logic [3:0] POS_CODE    = 4'd1;
   localparam logic [3:0] POS_AFTER   = 4'd2;
   localparam logic [3:0] POS_VERT_1  = 4'd4;
   localparam logic [3:0] POS_VERT_2  = 4'd7;
   localparam logic [3:0] POS_VERT_3  = 4'd10;
   localparam logic [3:0] POS_MAX     = 4'd12;

   logic [3:0] word_position_ff, word_position_in;
   logic [3:0] prim_length_ff, prim_length_in;
   logic [1:0] color_kind_ff, color_kind_in;
   logic       error_seen_ff, error_seen_in;

   logic [7:0] code;
   logic [3:0] dec_length;
   logic [1:0] dec_kind;
   logic       dec_known;
   logic [3:0] pos_inc;

   assign code    = code_byte & CODE_MASK;
   assign pos_inc = word_position_ff + 4'd1;

   // Decode primitive length and color kind
   always_comb begin
      dec_known = 1'b1;
      unique case (code)
         CODE_TRI_PLAIN:        begin dec_length = 4'd5;  dec_kind = KIND_NONE;    end
         CODE_TRI_FLAT:         begin dec_length = 4'd8;  dec_kind = KIND_FLAT;    end
         CODE_QUAD_PLAIN:       begin dec_length = 4'd6;  dec_kind = KIND_NONE;    end
         CODE_QUAD_FLAT:        begin dec_length = 4'd10; dec_kind = KIND_FLAT;    end
         CODE_TRI_SHADE_PLAIN:  begin dec_length = 4'd7;  dec_kind = KIND_NONE;    end
         CODE_TRI_GOURAUD:      begin dec_length = 4'd10; dec_kind = KIND_GOURAUD; end
         CODE_QUAD_SHADE_PLAIN: begin dec_length = 4'd9;  dec_kind = KIND_NONE;    end
         CODE_QUAD_GOURAUD:     begin dec_length = 4'd13; dec_kind = KIND_GOURAUD; end
         default: begin
            dec_length = 4'd0;
            dec_kind   = KIND_NONE;
            dec_known  = 1'b0;
         end
      endcase
   end

   // Advance position and pick the words to fade
   always_comb begin
      word_position_in = word_position_ff;
      prim_length_in   = prim_length_ff;
      color_kind_in    = color_kind_ff;
      error_seen_in    = error_seen_ff;
      status.fade_en   = 1'b0;

      if (!error_seen_ff) begin
         priority if (word_position_ff == POS_TAG) begin
            word_position_in = POS_CODE;
         end else if (word_position_ff == POS_CODE) begin
            prim_length_in = dec_length;
            color_kind_in  = dec_kind;
            if (dec_known) begin
               status.fade_en   = (dec_kind != KIND_NONE);
               word_position_in = POS_AFTER;
            end else begin
               error_seen_in = 1'b1;
            end
         end else begin
            status.fade_en = (color_kind_ff == KIND_GOURAUD) &&
                             (word_position_ff == POS_VERT_1 ||
                              word_position_ff == POS_VERT_2 ||
                              word_position_ff == POS_VERT_3);
            word_position_in = (pos_inc >= prim_length_ff) ? POS_TAG : pos_inc;
         end
      end

      status.bad_code = error_seen_in;

      // Drop all list state after the final word
      if (end_of_list) begin
         word_position_in = POS_TAG;
         prim_length_in   = 4'd0;
         color_kind_in    = KIND_NONE;
         error_seen_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_position_ff <= POS_TAG;
         prim_length_ff   <= 4'd0;
         color_kind_ff    <= KIND_NONE;
         error_seen_ff    <= 1'b0;
      end else if (accept) begin
         word_position_ff <= word_position_in;
         prim_length_ff   <= prim_length_in;
         color_kind_ff    <= color_kind_in;
         error_seen_ff    <= error_seen_in;
      end
   end

`ifndef SYNTHESIS
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      word_position_ff <= POS_MAX)
      else $error("word position beyond longest primitive");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (accept && error_seen_ff && !end_of_list) |=> error_seen_ff)
      else $error("error flag dropped inside a list");

   a_list_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_list) |=> (word_position_ff == POS_TAG && !error_seen_ff))
      else $error("state not cleared after final word");

   a_no_fade_on_error: assert property (@(posedge clock) disable iff (reset)
      accept |-> !(status.fade_en && status.bad_code))
      else $error("fade requested on a bad list");
`endif

endmodule

`default_nettype wire

// File: rtl/display_list_color_fader_top.sv
// Each accepted word is registered in main, or in skid if main is stalled.
// One word per cycle while req_stall is low; tracker updates once per word.
// A two-entry output stage (main plus skid) keeps req open while a result waits.
// Reset (synchronous, active high) clears the position tracker and error flag,
// sets all brightness bytes to neutral (128) and empties the output stage.
`timescale 1ns / 1ps
`default_nettype none

module display_list_color_fader_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire dlcf_pkg::req_type                      req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output dlcf_pkg::rsp_type                           rsp_data,
   input  wire logic                                   csr_we,
   input  wire logic [dlcf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [7:0]                             csr_wdata
);

   logic [7:0] bright_red_ff;
   logic [7:0] bright_green_ff;
   logic [7:0] bright_blue_ff;

   logic                     accept;
   logic                     pop;
   dlcf_pkg::trk_status_type trk_status;
   logic [7:0]               faded_red;
   logic [7:0]               faded_green;
   logic [7:0]               faded_blue;
   dlcf_pkg::rsp_type        result;

   dlcf_pkg::rsp_type main_ff, main_in;
   logic              main_valid_ff, main_valid_in;
   dlcf_pkg::rsp_type skid_ff, skid_in;
   logic              skid_valid_ff, skid_valid_in;

   // Brightness registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bright_red_ff   <= dlcf_pkg::BRIGHT_NEUTRAL;
         bright_green_ff <= dlcf_pkg::BRIGHT_NEUTRAL;
         bright_blue_ff  <= dlcf_pkg::BRIGHT_NEUTRAL;
      end else if (csr_we) begin
         unique case (csr_index)
            dlcf_pkg::CSR_BRIGHT_RED:   bright_red_ff   <= csr_wdata;
            dlcf_pkg::CSR_BRIGHT_GREEN: bright_green_ff <= csr_wdata;
            dlcf_pkg::CSR_BRIGHT_BLUE:  bright_blue_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign pop       = main_valid_ff && !rsp_stall;

   dlcf_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .code_byte   (req_data.list_word[31:24]),
      .end_of_list (req_data.end_of_list),
      .status      (trk_status)
   );

   // One lane per color channel
   dlcf_lane u_lane_red (
      .color_byte  (req_data.list_word[7:0]),
      .bright_byte (bright_red_ff),
      .faded_byte  (faded_red)
   );

   dlcf_lane u_lane_green (
      .color_byte  (req_data.list_word[15:8]),
      .bright_byte (bright_green_ff),
      .faded_byte  (faded_green)
   );

   dlcf_lane u_lane_blue (
      .color_byte  (req_data.list_word[23:16]),
      .bright_byte (bright_blue_ff),
      .faded_byte  (faded_blue)
   );

   // Merge lanes back into the word
   always_comb begin
      result.out_word = req_data.list_word;
      if (trk_status.fade_en) begin
         result.out_word = {req_data.list_word[31:24], faded_blue, faded_green, faded_red};
      end
      result.out_last = req_data.end_of_list;
      result.bad_code = trk_status.bad_code;
   end

   // Output stage: main register with a skid entry behind it
   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = result;
            main_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

`ifndef SYNTHESIS
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held with empty main register");

   a_stalled_beat_to_skid: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && rsp_stall && accept) |=> skid_valid_ff)
      else $error("beat accepted behind a stalled result was lost");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (!skid_valid_ff && main_valid_ff))
      else $error("skid entry did not move up after a taken beat");
`endif

endmodule

`default_nettype wire
